[hw/rtl/bba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helper function of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int SIZE_W  = 16;  // request size field
    localparam int VALUE_W = 16;  // result value field
    localparam int ORDER_W = 3;   // stored block order
    localparam int NEED_W  = 5;   // rounded-up log2 of a request, up to 16

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_BUDDY,
        ST_OWN,
        ST_RESP,
        ST_QCNT,
        ST_QENT
    } t_state;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FAIL  = 2'd1,
        KIND_COUNT = 2'd2,
        KIND_ENTRY = 2'd3
    } t_kind;

    // one result loaded into the output register
    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

    // ceil(log2(size)), a zero size counts as one unit
    function automatic logic [NEED_W-1:0] f_need(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] v;
        logic [NEED_W-1:0] n;
        v = (size == '0) ? '0 : size - SIZE_W'(1);
        n = '0;
        for (int b = 0; b < SIZE_W; b++) begin
            if (v[b]) begin
                n = NEED_W'(b + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/buddy_block_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Allocate-only buddy allocator over 2^total_order units, with block list
// kept in one synchronous memory and a result register on the output.
// ----------------------------------------------------------------------------
// usage
//   slave stream: one transfer per command. tuser selects allocate (0) or
//   query (1); tdata carries owner id and request size.
//   master stream: allocate gives one transfer (kind allocated or failed);
//   query gives the block count, then one owner per block in address order,
//   tlast on the final one. kind travels in tuser, value in tdata.
//   config: i_cfg_wr_en writes total_order (clamped to MAX_ORDER) and resets
//   the list to one free block; write only while no command is in flight.
// timing
//   allocate: blocks are scanned one per cycle over the memory read port,
//   then the tail entries are moved up one per cycle, then one buddy is
//   written per split, then the owner entry, before the result.
//   query: one result per cycle when not stalled.
// reset
//   one free block of order min(5, MAX_ORDER); no memory sweep is needed,
//   entry 0 reads as that block until first written.
// stall
//   the output register holds a result while tready is low; the sequencer
//   waits for it, and a new command is taken while the last result waits.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int MAX_ORDER = 5,
    parameter int ID_WIDTH  = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire [2:0]   i_cfg_wr_data,    // total_order
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [31:0]  i_s_axis_tdata,   // [15:0] owner_id, [31:16] request_size
    input  wire [0:0]   i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] result_value
    output logic [1:0]  o_m_axis_tuser,   // [1:0] result_kind
    output logic        o_m_axis_tlast    // last
);
    import bba_pkg::*;

    t_result                w_res;
    logic                   w_out_free;
    logic [ORDER_W-1:0]     w_total_order;
    logic                   w_rd_en;
    logic [MAX_ORDER-1:0]   w_rd_addr;
    logic                   w_wr_en;
    logic [MAX_ORDER-1:0]   w_wr_addr;
    logic [ORDER_W-1:0]     w_wr_order;
    logic [ID_WIDTH-1:0]    w_wr_owner;
    logic [ORDER_W-1:0]     w_rd_order;
    logic [ID_WIDTH-1:0]    w_rd_owner;

    // output register
    logic                   r_ov;
    t_kind                  r_okind;
    logic [VALUE_W-1:0]     r_ovalue;
    logic                   r_olast;

    // slot is free when empty or draining this cycle
    assign w_out_free = !r_ov || i_m_axis_tready;

    bba_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .ID_WIDTH  (ID_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .i_func         (i_s_axis_tuser[0]),
        .i_owner_id     (i_s_axis_tdata[15:0]),
        .i_request_size (i_s_axis_tdata[31:16]),
        .i_out_free     (w_out_free),
        .o_res          (w_res),
        .o_total_order  (w_total_order),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_order     (w_wr_order),
        .o_wr_owner     (w_wr_owner),
        .i_rd_order     (w_rd_order),
        .i_rd_owner     (w_rd_owner)
    );

    bba_store #(
        .AW       (MAX_ORDER),
        .ID_WIDTH (ID_WIDTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (i_cfg_wr_en),
        .i_init_order (w_total_order),
        .i_rd_en      (w_rd_en),
        .i_rd_addr    (w_rd_addr),
        .i_wr_en      (w_wr_en),
        .i_wr_addr    (w_wr_addr),
        .i_wr_order   (w_wr_order),
        .i_wr_owner   (w_wr_owner),
        .o_rd_order   (w_rd_order),
        .o_rd_owner   (w_rd_owner)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res.valid) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    // result payload, loaded only into a free slot
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_okind  <= w_res.kind;
            r_ovalue <= w_res.value;
            r_olast  <= w_res.last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_ovalue;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

endmodule
`default_nettype wire

[hw/rtl/bba_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bba_store
// Block list memory: order and owner per entry, one write and one registered
// read per cycle. Entry 0 reads as one free block of the configured order
// until it is first written after reset or a configuration write.
// ----------------------------------------------------------------------------
module bba_store #(
    parameter int AW       = 5,
    parameter int ID_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_init,
    input  wire [bba_pkg::ORDER_W-1:0]  i_init_order,
    input  wire                         i_rd_en,
    input  wire [AW-1:0]                i_rd_addr,
    input  wire                         i_wr_en,
    input  wire [AW-1:0]                i_wr_addr,
    input  wire [bba_pkg::ORDER_W-1:0]  i_wr_order,
    input  wire [ID_WIDTH-1:0]          i_wr_owner,
    output logic [bba_pkg::ORDER_W-1:0] o_rd_order,
    output logic [ID_WIDTH-1:0]         o_rd_owner
);
    import bba_pkg::*;

    localparam int DEPTH = 1 << AW;
    localparam int DW    = ORDER_W + ID_WIDTH;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_fresh;
    logic          r_rd_fresh;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_order, i_wr_owner};
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // entry 0 stays virtual until its first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_rd_fresh <= 1'b0;
        end else begin
            if (i_init) begin
                r_fresh <= 1'b1;
            end else if (i_wr_en && (i_wr_addr == '0)) begin
                r_fresh <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_fresh <= r_fresh && (i_rd_addr == '0);
            end
        end
    end

    assign o_rd_order = r_rd_fresh ? i_init_order : r_rd_data[DW-1 -: ORDER_W];
    assign o_rd_owner = r_rd_fresh ? '0 : r_rd_data[ID_WIDTH-1:0];

endmodule
`default_nettype wire

[hw/rtl/bba_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: first-fit scan, tail shift, buddy insertion, owner write and
// query readout over the block list memory.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int MAX_ORDER = 5,
    parameter int ID_WIDTH  = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire [bba_pkg::ORDER_W-1:0]  i_cfg_wr_data,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_func,
    input  wire [bba_pkg::SIZE_W-1:0]   i_owner_id,
    input  wire [bba_pkg::SIZE_W-1:0]   i_request_size,
    input  wire                         i_out_free,
    output bba_pkg::t_result            o_res,
    output logic [bba_pkg::ORDER_W-1:0] o_total_order,
    output logic                        o_rd_en,
    output logic [MAX_ORDER-1:0]        o_rd_addr,
    output logic                        o_wr_en,
    output logic [MAX_ORDER-1:0]        o_wr_addr,
    output logic [bba_pkg::ORDER_W-1:0] o_wr_order,
    output logic [ID_WIDTH-1:0]         o_wr_owner,
    input  wire [bba_pkg::ORDER_W-1:0]  i_rd_order,
    input  wire [ID_WIDTH-1:0]          i_rd_owner
);
    import bba_pkg::*;

    localparam int AW = MAX_ORDER;
    localparam int CW = MAX_ORDER + 1;
    localparam logic [ORDER_W-1:0] RST_ORDER =
        (MAX_ORDER < 5) ? ORDER_W'(MAX_ORDER) : ORDER_W'(5);

    function automatic logic [ORDER_W-1:0] f_clamp(input logic [ORDER_W-1:0] v);
        return (int'(v) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : v;
    endfunction

    t_state               r_state, n_state;
    logic [ORDER_W-1:0]   r_total_order;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_i;
    logic [AW-1:0]        r_j;
    logic [ORDER_W-1:0]   r_k;
    logic [ORDER_W-1:0]   r_need;
    logic [ORDER_W-1:0]   r_bord;
    logic [ID_WIDTH-1:0]  r_id;
    t_kind                r_kind;

    logic [NEED_W-1:0]          w_need;
    logic                       w_too_big;
    logic                       w_fit;
    logic [ORDER_W-1:0]         w_k;
    logic [CW-1:0]              w_idx_inc;
    logic                       w_scan_end;
    logic                       w_q_last;
    logic [AW-1:0]              w_last_addr;
    logic                       w_shift_more;
    logic                       w_buddy_end;
    logic [CW-1:0]              w_shift_dst;
    logic [ID_WIDTH+SIZE_W-1:0] w_id_ext;
    logic [ID_WIDTH+VALUE_W-1:0] w_own_ext;

    assign w_need       = f_need(i_request_size);
    assign w_too_big    = w_need > NEED_W'(r_total_order);
    assign w_fit        = (i_rd_owner == '0) && (i_rd_order >= r_need);
    assign w_k          = i_rd_order - r_need;
    assign w_idx_inc    = {1'b0, r_idx} + CW'(1);
    assign w_scan_end   = w_idx_inc >= r_count;
    assign w_q_last     = w_idx_inc == r_count;
    assign w_last_addr  = AW'(r_count - CW'(1));
    assign w_shift_more = {1'b0, r_j} > ({1'b0, r_i} + CW'(1));
    assign w_buddy_end  = {1'b0, r_j} == ({1'b0, r_i} + CW'(r_k));
    assign w_shift_dst  = {1'b0, r_j} + CW'(r_k);
    assign w_id_ext     = {{ID_WIDTH{1'b0}}, i_owner_id};
    assign w_own_ext    = {{VALUE_W{1'b0}}, i_rd_owner};
    assign o_total_order = r_total_order;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func) begin
                        n_state = ST_QCNT;
                    end else if (w_too_big) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_fit) begin
                    if (w_k == '0) begin
                        n_state = ST_OWN;
                    end else if (!w_scan_end) begin
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_BUDDY;
                    end
                end else if (w_scan_end) begin
                    n_state = ST_RESP;
                end
            end
            ST_SHIFT: begin
                if (!w_shift_more) begin
                    n_state = ST_BUDDY;
                end
            end
            ST_BUDDY: begin
                if (w_buddy_end) begin
                    n_state = ST_OWN;
                end
            end
            ST_OWN:  n_state = ST_RESP;
            ST_RESP: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QCNT: begin
                if (i_out_free) begin
                    n_state = ST_QENT;
                end
            end
            ST_QENT: begin
                if (i_out_free && w_q_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory ports and results
    always_comb begin
        o_in_ready = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_j;
        o_wr_order = i_rd_order;
        o_wr_owner = i_rd_owner;
        o_res      = '{valid: 1'b0, kind: KIND_ALLOC, value: '0, last: 1'b1};
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_rd_en    = i_in_valid && !i_func;
            end
            ST_SCAN: begin
                if (!w_fit) begin
                    o_rd_en   = !w_scan_end;
                    o_rd_addr = w_idx_inc[AW-1:0];
                end else begin
                    o_rd_en   = (w_k != '0) && !w_scan_end;
                    o_rd_addr = w_last_addr;
                end
            end
            ST_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = w_shift_dst[AW-1:0];
                o_rd_en   = w_shift_more;
                o_rd_addr = r_j - AW'(1);
            end
            ST_BUDDY: begin
                o_wr_en    = 1'b1;
                o_wr_addr  = r_j;
                o_wr_order = r_bord;
                o_wr_owner = '0;
            end
            ST_OWN: begin
                o_wr_en    = 1'b1;
                o_wr_addr  = r_i;
                o_wr_order = r_need;
                o_wr_owner = r_id;
            end
            ST_RESP: begin
                o_res = '{valid: i_out_free, kind: r_kind, value: '0, last: 1'b1};
            end
            ST_QCNT: begin
                o_rd_en = i_out_free;
                o_res   = '{valid: i_out_free, kind: KIND_COUNT,
                            value: VALUE_W'(r_count), last: (r_count == '0)};
            end
            ST_QENT: begin
                o_rd_en   = i_out_free && !w_q_last;
                o_rd_addr = w_idx_inc[AW-1:0];
                o_res     = '{valid: i_out_free, kind: KIND_ENTRY,
                              value: w_own_ext[VALUE_W-1:0], last: w_q_last};
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_total_order <= RST_ORDER;
            r_count       <= CW'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_total_order <= f_clamp(i_cfg_wr_data);
                r_count       <= CW'(1);
            end else if (r_state == ST_OWN) begin
                r_count <= r_count + CW'(r_k);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_idx  <= '0;
                r_id   <= w_id_ext[ID_WIDTH-1:0];
                r_need <= w_need[ORDER_W-1:0];
                r_kind <= KIND_FAIL;
            end
            ST_SCAN: begin
                if (w_fit) begin
                    r_i    <= r_idx;
                    r_k    <= w_k;
                    r_bord <= r_need;
                    r_j    <= w_scan_end ? w_idx_inc[AW-1:0] : w_last_addr;
                end else if (!w_scan_end) begin
                    r_idx <= w_idx_inc[AW-1:0];
                end
            end
            ST_SHIFT: begin
                r_j <= w_shift_more ? r_j - AW'(1) : r_i + AW'(1);
            end
            ST_BUDDY: begin
                if (!w_buddy_end) begin
                    r_j    <= r_j + AW'(1);
                    r_bord <= r_bord + ORDER_W'(1);
                end
            end
            ST_OWN: begin
                r_kind <= KIND_ALLOC;
            end
            ST_QENT: begin
                if (i_out_free && !w_q_last) begin
                    r_idx <= w_idx_inc[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // a finished split grows the list by the number of buddies
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OWN) |=> (r_count == $past(r_count) + CW'($past(r_k))))
        else $error("block count did not grow by the split depth");

    // tail moves only upward, above the split block
    a_shift_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> ((o_wr_addr > r_j) && (o_wr_addr > r_i)))
        else $error("tail shift writes below its source");

    // the scan never looks past the end of the list
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ({1'b0, r_idx} < r_count))
        else $error("scan index beyond block count");

endmodule
`default_nettype wire

[verif/bba_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the command, result and config channels of the buddy block
// allocator, keeps its own copy of the block list, works out the results of
// every accepted command and compares them field by field on arrival.
// ----------------------------------------------------------------------------
package bba_tb_pkg;

    // command selector carried in the slave tuser
    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

endpackage

module bba_checker #(
    parameter int MAX_ORDER = 5
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire [2:0]   i_cfg_wr_data,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire [31:0]  i_s_axis_tdata,   // [15:0] owner_id, [31:16] request_size
    input  wire [0:0]   i_s_axis_tuser,   // [0] func
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire [15:0]  i_m_axis_tdata,   // [15:0] result_value
    input  wire [1:0]   i_m_axis_tuser,   // [1:0] result_kind
    input  wire         i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_owed_count
);
    import bba_pkg::*;
    import bba_tb_pkg::*;

    localparam int SLOTS = 1 << MAX_ORDER;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_beat;

    // shadow of the block list
    logic [ORDER_W-1:0] blk_order [SLOTS];
    logic [15:0]        blk_owner [SLOTS];
    int                 blk_count;
    int                 span_order;

    t_beat owed_results [$];

    task automatic owe(input t_kind kind, input logic [VALUE_W-1:0] value, input logic last);
        t_beat b;
        b.kind  = kind;
        b.value = value;
        b.last  = last;
        owed_results.push_back(b);
    endtask

    task automatic wipe_list(input int order);
        span_order = order;
        for (int i = 0; i < SLOTS; i++) begin
            blk_order[i] = '0;
            blk_owner[i] = '0;
        end
        blk_order[0] = ORDER_W'(order);
        blk_count    = 1;
    endtask

    // first fit in address order, halving until the rounded size fits
    task automatic alloc_block(input logic [15:0] owner, input logic [15:0] size,
                               output logic ok);
        int need;
        int slot;
        int units;
        units = (size == 0) ? 1 : int'(size);
        need  = 0;
        slot  = -1;
        ok    = 1'b0;
        while (need < 16 && (1 << need) < units) begin
            need++;
        end
        if (need <= span_order) begin
            for (int i = 0; i < blk_count; i++) begin
                if (slot < 0 && blk_owner[i] == 0 && int'(blk_order[i]) >= need) begin
                    slot = i;
                end
            end
        end
        if (slot >= 0) begin
            while (int'(blk_order[slot]) > need && blk_count < SLOTS) begin
                blk_order[slot] = blk_order[slot] - 1'b1;
                for (int j = blk_count; j > slot + 1; j--) begin
                    blk_order[j] = blk_order[j-1];
                    blk_owner[j] = blk_owner[j-1];
                end
                blk_order[slot+1] = blk_order[slot];
                blk_owner[slot+1] = '0;
                blk_count++;
            end
            blk_owner[slot] = owner;
            ok = 1'b1;
        end
    endtask

    task automatic list_blocks();
        owe(KIND_COUNT, VALUE_W'(blk_count), blk_count == 0);
        for (int i = 0; i < blk_count; i++) begin
            owe(KIND_ENTRY, blk_owner[i], i + 1 == blk_count);
        end
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        logic  ok;
        if (!i_rst_n) begin
            wipe_list(MAX_ORDER);
            owed_results.delete();
            o_fail_count = 0;
        end else begin
            // result transfer against the oldest owed result
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result with nothing owed: kind %0d value %0d last %0d",
                           i_m_axis_tuser, i_m_axis_tdata, i_m_axis_tlast);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_m_axis_tuser != want.kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.kind, i_m_axis_tuser);
                        o_fail_count++;
                    end
                    if (i_m_axis_tdata != want.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               want.value, i_m_axis_tdata);
                        o_fail_count++;
                    end
                    if (i_m_axis_tlast != want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                wipe_list((int'(i_cfg_wr_data) > MAX_ORDER) ? MAX_ORDER
                                                             : int'(i_cfg_wr_data));
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (t_func'(i_s_axis_tuser[0]) == FUNC_QUERY) begin
                    list_blocks();
                end else begin
                    alloc_block(i_s_axis_tdata[15:0], i_s_axis_tdata[31:16], ok);
                    owe(ok ? KIND_ALLOC : KIND_FAIL, '0, 1'b1);
                end
            end
        end
        o_owed_count = owed_results.size();
    end

endmodule

[verif/tb_buddy_block_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Drives allocate and query commands into the buddy block allocator under
// random source gaps and sink stalls, rewrites total_order between phases,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
    import bba_pkg::*;
    import bba_tb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // settle time after the last result, longer than the worst allocation takes
    localparam int SETTLE_CYCLES = 80;
    // every command yields a result, a short pause is enough before a config write
    localparam int CFG_GUARD     = 10;
    localparam int PHASES        = 12;
    localparam int PHASE_LEN     = 34;

    // size profiles of a random phase
    localparam int SIZES_TINY  = 0;
    localparam int SIZES_MIXED = 1;
    localparam int SIZES_WIDE  = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [15:0] owner_id, [31:16] request_size
    logic [0:0]  i_s_axis_tuser;   // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;   // [15:0] result_value
    logic [1:0]  o_m_axis_tuser;   // [1:0] result_kind
    logic        o_m_axis_tlast;

    int fail_count;
    int owed_count;
    int cycle_cnt;
    int stall_left = 0;
    bit quiet;      // no gaps or stalls in the closing stretch

    buddy_block_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    bba_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_owed_count    (owed_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // sink side: ready drops for random bursts, with long runs
    // of steady ready between them
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_left      <= $urandom_range(0, 10);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // one command transfer, with a random source gap in front of it;
    // called and returning in the time step of a rising edge
    task automatic send_cmd(input t_func func, input logic [15:0] owner,
                            input logic [15:0] size);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= func;
        i_s_axis_tdata  <= {size, owner};
        // ready only moves on rising edges, so the falling edge shows
        // what the next rising edge will see
        @(negedge i_clk);
        while (!o_s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // hold the source until every owed result has been taken
    task automatic drain_results(input int extra);
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (owed_count != 0) @(negedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // total_order write, only with the block idle; the list restarts as one
    // free block
    task automatic write_total_order(input logic [2:0] order);
        drain_results(CFG_GUARD);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= order;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_size(input int profile);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 6);
        if (profile == SIZES_TINY) begin
            return 16'($urandom_range(0, 2));
        end else if (profile == SIZES_MIXED) begin
            if (r < 55) begin
                return 16'($urandom_range(0, 4));
            end else if (r < 80) begin
                return 16'($urandom_range(5, 40));
            end else if (r < 92) begin
                // just under, at and just over a power of two
                return 16'((1 << k) + $urandom_range(0, 2) - 1);
            end
            return 16'($urandom);
        end
        if (r < 50) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 64));
    endfunction

    function automatic logic [15:0] pick_owner();
        if ($urandom_range(0, 9) == 0) begin
            return '0;
        end
        return 16'($urandom);
    endfunction

    // run limit, far above the slowest legal run
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [2:0] phase_order [PHASES];
        int         profile;
        t_func      func;

        phase_order = '{3'd5, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6,
                        3'd4, 3'd1, 3'd5, 3'd3, 3'd5, 3'd5};

        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = FUNC_ALLOC;
        quiet           = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset order of 5 ----
        send_cmd(FUNC_QUERY, 16'h0000, 16'h0000);   // one free block
        send_cmd(FUNC_ALLOC, 16'hFFFF, 16'h0000);   // zero size counts as one, full split
        send_cmd(FUNC_ALLOC, 16'h0000, 16'h0001);   // owner zero, block stays free
        send_cmd(FUNC_ALLOC, 16'h8001, 16'h0001);   // reuses that same block
        send_cmd(FUNC_ALLOC, 16'h1234, 16'h0003);   // rounds up to four
        send_cmd(FUNC_ALLOC, 16'h00AA, 16'hFFFF);   // larger than the memory
        send_cmd(FUNC_ALLOC, 16'h5555, 16'h0010);   // upper half
        send_cmd(FUNC_ALLOC, 16'hAAAA, 16'h0020);   // fits in size, no free block
        send_cmd(FUNC_QUERY, 16'hFFFF, 16'hFFFF);

        // smallest memory: a single unit
        write_total_order(3'd0);
        send_cmd(FUNC_ALLOC, 16'h0101, 16'h0002);   // too large
        send_cmd(FUNC_ALLOC, 16'h0007, 16'h0001);
        send_cmd(FUNC_ALLOC, 16'h0008, 16'h0001);   // memory exhausted
        send_cmd(FUNC_QUERY, 16'h0000, 16'h0000);

        // order above the maximum saturates
        write_total_order(3'd7);
        send_cmd(FUNC_ALLOC, 16'h0F0F, 16'h0020);   // whole memory in one block
        send_cmd(FUNC_QUERY, 16'h0000, 16'h0000);
        write_total_order(3'd6);
        send_cmd(FUNC_ALLOC, 16'hF0F0, 16'h0021);   // one past the memory size
        send_cmd(FUNC_ALLOC, 16'h4000, 16'h8000);   // top size bit alone
        send_cmd(FUNC_QUERY, 16'h0000, 16'h0000);

        // ---- random phases, each on a freshly written order ----
        for (int p = 0; p < PHASES; p++) begin
            write_total_order(phase_order[p]);
            // closing phases run with no gaps or stalls
            quiet   = (p >= PHASES - 2);
            profile = (phase_order[p] == 3'd5 && p < 4) ? SIZES_TINY
                    : (p % 3 == 2) ? SIZES_WIDE : SIZES_MIXED;
            for (int n = 0; n < PHASE_LEN; n++) begin
                func = ($urandom_range(0, 5) == 0) ? FUNC_QUERY : FUNC_ALLOC;
                send_cmd(func, pick_owner(), pick_size(profile));
            end
        end

        drain_results(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[buddy_block_allocator.f]
hw/rtl/bba_pkg.sv
hw/rtl/bba_store.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator.sv
verif/bba_checker.sv
verif/tb_buddy_block_allocator.sv
